### design/tcw_pkg.sv
// Package for the text console writer: payload structs, operation and register codes,
// the command passed from the front end to the back end, and default geometry.
// No dependencies.
`default_nettype none

package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int CMD_QUEUE_AW    = $clog2(CMD_QUEUE_DEPTH);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_BACKGROUND = 1'b0;
  localparam logic REG_FOREGROUND = 1'b1;

  localparam logic [3:0] BACKGROUND_RESET = 4'd0;
  localparam logic [3:0] FOREGROUND_RESET = 4'd7;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_NEWLINE = 3'd1,
    CMD_READ    = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_NOP     = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] attr;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
    logic       in_range;
  } cmd_t;

endpackage

`default_nettype wire

### design/text_console_writer.sv
// Text console writer: a character screen of ROWS x COLUMNS cells, 16 bits each.
// Requests enter through a queue-like port (push/full, payload in_data) and each
// yields exactly one result on a queue-like port (empty/pop, payload out_data):
// the cell read, or zero, and the cursor position afterwards.
// The colour registers are written through cfg_we/cfg_index/cfg_data while idle;
// the user is bound to this, the block itself does not enforce it. A put into a
// row that is stale since reset, a clear or a scroll first zeroes that row: the
// back end finds the row stale and then zeroes one cell a cycle through the single
// memory port. Otherwise the back end finishes a put each cycle while the result
// register is free, and a read waits in ST_READ for the registered memory read
// before the next request is taken. Clear and scroll zero no cells: they change
// only row valid bits, the rotating row offset and the cursor. Reset clears the
// cursor, queues and row valid bits and sets the colours to their defaults; there
// is no clearing pass. While pop is held low, results stay in the output register,
// and the two-entry request queue still takes requests until full.
// Depends on tcw_pkg, tcw_front and tcw_back.
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire in_item_t   in_data,
  output logic            empty,
  input  wire logic       pop,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .out_data  (out_data),
    .pop       (pop)
  );

endmodule

`default_nettype wire

### design/tcw_front.sv
// Front end of the text console writer: colour registers, request decoding
// and a short command queue towards the back end. Depends on tcw_pkg.
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_data,
  input  wire logic     cfg_we,
  input  wire logic     cfg_index,
  input  wire logic [3:0] cfg_data,
  output logic          cmd_valid,
  output cmd_t          cmd,
  input  wire logic     cmd_pop
);

  logic [3:0] background_r;
  logic [3:0] foreground_r;

  cmd_t                    queue_r [CMD_QUEUE_DEPTH];
  logic [CMD_QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_QUEUE_AW:0]   count_r, count_nxt;

  cmd_t classified;
  logic accept;
  logic take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= BACKGROUND_RESET;
      foreground_r <= FOREGROUND_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_BACKGROUND) begin
        background_r <= cfg_data;
      end else begin
        foreground_r <= cfg_data;
      end
    end
  end

  // The read range check and the cell attribute are settled here, so the
  // back end only has to act on the command kind.
  always_comb begin
    classified.attr      = {background_r, foreground_r};
    classified.char_code = in_data.char_code;
    classified.cell_row  = in_data.cell_row;
    classified.cell_col  = in_data.cell_col;
    classified.in_range  = (32'(in_data.cell_row) < ROWS) &&
                           (32'(in_data.cell_col) < COLUMNS);
    case (in_data.operation)
      OP_PUT: begin
        classified.kind = (in_data.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_READ:  classified.kind = CMD_READ;
      OP_CLEAR: classified.kind = CMD_CLEAR;
      default:  classified.kind = CMD_NOP;
    endcase
  end

  assign full      = (count_r == (CMD_QUEUE_AW+1)'(CMD_QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = queue_r[rd_ptr_r];
  assign accept    = push && !full;
  assign take      = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (accept && !take) begin
      count_nxt = count_r + 1'b1;
    end else if (take && !accept) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue_r[wr_ptr_r] <= classified;
    end
  end

endmodule

`default_nettype wire

### design/tcw_back.sv
// Back end of the text console writer: screen memory, cursor, scroll offset,
// row valid bits and the result register. Depends on tcw_pkg.
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      empty,
  output out_item_t out_data,
  input  wire logic pop
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [RW:0]   ROWS_EXT = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_READ  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic [RW-1:0]   top_r, top_nxt;
  logic [ROWS-1:0] row_valid_r, row_valid_nxt;
  logic [CW-1:0]   sweep_col_r, sweep_col_nxt;
  logic            rd_hit_r, rd_hit_nxt;
  logic [15:0]     rd_data_r;
  out_item_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic [15:0]     mem [CELLS];
  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_addr;
  logic [15:0]     mem_wdata;

  logic            slot_free;
  logic            res_push;
  logic [15:0]     res_value;
  logic [RW-1:0]   cur_phys;
  logic [RW-1:0]   rd_phys;
  logic            line_end;

  // Logical rows are rotated by the scroll offset, so a scroll never moves cells.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, lr} + {1'b0, top};
    if (s >= ROWS_EXT) begin
      s = s - ROWS_EXT;
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] pr,
                                              input logic [CW-1:0] c);
    return AW'(AW'(pr) * COLS_A + AW'(c));
  endfunction

  assign cur_phys  = phys_row(cur_row_r, top_r);
  assign rd_phys   = phys_row(RW'(cmd.cell_row), top_r);
  assign slot_free = !out_valid_r || pop;

  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    row_valid_nxt = row_valid_r;
    sweep_col_nxt = sweep_col_r;
    rd_hit_nxt    = rd_hit_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res_value     = '0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = cell_addr(cur_phys, cur_col_r);
    mem_wdata     = {cmd.attr, cmd.char_code};
    line_end      = 1'b0;

    case (state_r)
      ST_RUN: begin
        if (cmd_valid && slot_free) begin
          case (cmd.kind)
            CMD_PUT: begin
              if (!row_valid_r[cur_phys]) begin
                // First write to a stale row: zero it before the request is done.
                state_nxt     = ST_SWEEP;
                sweep_col_nxt = '0;
              end else begin
                mem_we   = 1'b1;
                cmd_pop  = 1'b1;
                res_push = 1'b1;
                if (cur_col_r == LAST_COL) begin
                  line_end = 1'b1;
                end else begin
                  cur_col_nxt = cur_col_r + 1'b1;
                end
              end
            end
            CMD_NEWLINE: begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
              line_end = 1'b1;
            end
            CMD_READ: begin
              cmd_pop = 1'b1;
              if (cmd.in_range) begin
                mem_re     = 1'b1;
                mem_addr   = cell_addr(rd_phys, CW'(cmd.cell_col));
                rd_hit_nxt = row_valid_r[rd_phys];
                state_nxt  = ST_READ;
              end else begin
                res_push = 1'b1;
              end
            end
            CMD_CLEAR: begin
              cmd_pop       = 1'b1;
              res_push      = 1'b1;
              row_valid_nxt = '0;
              top_nxt       = '0;
              cur_row_nxt   = '0;
              cur_col_nxt   = '0;
            end
            default: begin
              cmd_pop  = 1'b1;
              res_push = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push  = 1'b1;
        res_value = rd_hit_r ? rd_data_r : 16'd0;
        state_nxt = ST_RUN;
      end
      ST_SWEEP: begin
        mem_we        = 1'b1;
        mem_addr      = cell_addr(cur_phys, sweep_col_r);
        mem_wdata     = '0;
        sweep_col_nxt = sweep_col_r + 1'b1;
        if (sweep_col_r == LAST_COL) begin
          row_valid_nxt[cur_phys] = 1'b1;
          state_nxt               = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase

    if (line_end) begin
      cur_col_nxt = '0;
      if (cur_row_r == LAST_ROW) begin
        // Scroll: the old top row becomes the new, empty bottom row.
        row_valid_nxt[top_r] = 1'b0;
        top_nxt = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
      end else begin
        cur_row_nxt = cur_row_r + 1'b1;
      end
    end

    out_nxt.cell_value = res_value;
    out_nxt.cursor_row = 5'(cur_row_nxt);
    out_nxt.cursor_col = 7'(cur_col_nxt);

    out_valid_nxt = out_valid_r;
    if (res_push) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      row_valid_r <= '0;
      sweep_col_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      row_valid_r <= row_valid_nxt;
      sweep_col_r <= sweep_col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_hit_r <= rd_hit_nxt;
    if (res_push) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

endmodule

`default_nettype wire

### verif/tcw_screen_checker.sv
// Scoreboard for the text console writer: keeps its own copy of the screen, cursor
// and colours, predicts one result per accepted request and checks each popped result.
// Depends on tcw_pkg only.
`timescale 1ns / 100ps

module tcw_screen_checker import tcw_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire logic      full,
  input  wire in_item_t  in_data,
  input  wire logic      empty,
  input  wire logic      pop,
  input  wire out_item_t out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [3:0] cfg_data,
  output int             failures,
  output int             pending
);

  localparam int COLUMNS     = DEF_COLUMNS;
  localparam int ROWS        = DEF_ROWS;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 40;

  logic [15:0] screen [CELLS];
  int unsigned cursor_row;
  int unsigned cursor_col;
  logic [3:0]  bg_colour;
  logic [3:0]  fg_colour;
  out_item_t   awaited_results [$];

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = '0;
    end
  endfunction

  // Applies one request to the screen copy and returns the result it must produce.
  function automatic out_item_t console_response(in_item_t req);
    out_item_t res;
    res = '0;
    case (req.operation)
      OP_PUT: begin
        if (req.char_code == NEWLINE_CODE) begin
          cursor_col = 0;
          cursor_row++;
        end else begin
          screen[cursor_row * COLUMNS + cursor_col] = {bg_colour, fg_colour, req.char_code};
          cursor_col++;
        end
        if (cursor_col >= COLUMNS) begin
          cursor_col = 0;
          cursor_row++;
        end
        // Past the bottom row the whole screen moves up and the last line is blanked.
        if (cursor_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = '0;
          end
          cursor_row = ROWS - 1;
        end
      end
      OP_READ: begin
        if (req.cell_row < ROWS && req.cell_col < COLUMNS) begin
          res.cell_value = screen[req.cell_row * COLUMNS + req.cell_col];
        end
      end
      OP_CLEAR: begin
        blank_screen();
        cursor_row = 0;
        cursor_col = 0;
      end
      default: begin
      end
    endcase
    res.cursor_row = cursor_row[4:0];
    res.cursor_col = cursor_col[6:0];
    return res;
  endfunction

  task automatic report(string field, logic [15:0] want, logic [15:0] got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      blank_screen();
      cursor_row = 0;
      cursor_col = 0;
      bg_colour  = BACKGROUND_RESET;
      fg_colour  = FOREGROUND_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BACKGROUND) begin
          bg_colour = cfg_data;
        end else begin
          fg_colour = cfg_data;
        end
      end
      if (pop && !empty) begin
        if (awaited_results.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.cell_value !== want.cell_value) begin
            report("cell_value", want.cell_value, out_data.cell_value);
          end
          if (out_data.cursor_row !== want.cursor_row) begin
            report("cursor_row", 16'(want.cursor_row), 16'(out_data.cursor_row));
          end
          if (out_data.cursor_col !== want.cursor_col) begin
            report("cursor_col", 16'(want.cursor_col), 16'(out_data.cursor_col));
          end
        end
      end
      if (push && !full) begin
        awaited_results.push_back(console_response(in_data));
      end
    end
    pending = awaited_results.size();
  end

endmodule

### verif/tb_text_console_writer.sv
// Top of the text console writer testbench: clock, reset, request and colour stimulus,
// result popping and the verdict. Depends on tcw_pkg, the design and tcw_screen_checker.
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ROWS        = DEF_ROWS;
  localparam int         COLUMNS     = DEF_COLUMNS;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 241;
  localparam int         HOLD_CYCLES = 300;
  localparam int         RUN_LIMIT   = 1000000;

  typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PATTERN} pop_mode_t;
  typedef enum int {TEXT_PHASE, SCROLL_PHASE, MIXED_PHASE} phase_kind_t;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;
  logic      cfg_we;
  logic      cfg_index;
  logic [3:0] cfg_data;
  int        failures;
  int        pending;
  int        cycle_count;
  int        burst_left;
  bit        hold_off_req;

  text_console_writer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  tcw_screen_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t pack_request(logic [1:0] op, logic [7:0] code,
                                            logic [4:0] row, logic [6:0] col);
    in_item_t req;
    req.operation = op;
    req.char_code = code;
    req.cell_row  = row;
    req.cell_col  = col;
    return req;
  endfunction

  // Scroll phases are newline-heavy so the screen fills and scrolls; text phases
  // write long lines so the cursor wraps.
  function automatic in_item_t random_request(phase_kind_t kind);
    in_item_t req;
    int       roll;
    int       newline_pct;
    int       clear_pct;
    int       unused_pct;
    req = pack_request(OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
    case (kind)
      TEXT_PHASE: begin
        newline_pct = 1;
        clear_pct   = 0;
        unused_pct  = 1;
      end
      SCROLL_PHASE: begin
        newline_pct = 45;
        clear_pct   = 0;
        unused_pct  = 0;
      end
      default: begin
        newline_pct = 15;
        clear_pct   = 4;
        unused_pct  = 4;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < clear_pct) begin
      req.operation = OP_CLEAR;
    end else if (roll < clear_pct + unused_pct) begin
      req.operation = OP_UNUSED;
    end else if (roll < 65) begin
      if ($urandom_range(0, 99) < newline_pct) begin
        req.char_code = NEWLINE_CODE;
      end
    end else begin
      req.operation = OP_READ;
      // Most reads land on the screen, leaning towards the left where short lines sit.
      if ($urandom_range(0, 9) != 0) begin
        req.cell_row = 5'($urandom_range(0, ROWS - 1));
        req.cell_col = $urandom_range(0, 1) ? 7'($urandom_range(0, 15))
                                            : 7'($urandom_range(0, COLUMNS - 1));
      end
    end
    return req;
  endfunction

  // Offers one request, then ends the burst with a random gap when it runs out.
  task automatic send_request(in_item_t req);
    int gap;
    push    <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (full);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops sending and waits until every expected result has been popped. It first lets
  // the clock tick so that the checker has counted the last accepted request.
  task automatic drain(int settle);
    push       <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_colours(logic [3:0] bg, logic [3:0] fg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BACKGROUND;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_index <= REG_FOREGROUND;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: a pop pattern that changes every so often, plus one long hold-off
  // on request so that the request queue fills and full is seen.
  initial begin
    pop_mode_t  mode;
    int         mode_left;
    logic [7:0] pattern;
    mode      = POP_ALWAYS;
    mode_left = 0;
    pattern   = 8'h01;
    pop       = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left <= 0) begin
          mode      = pop_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 80);
          pattern   = 8'($urandom) | 8'h01;
        end
        mode_left--;
        case (mode)
          POP_ALWAYS:  pop <= 1'b1;
          POP_MOSTLY:  pop <= ($urandom_range(0, 3) != 0);
          POP_RARELY:  pop <= ($urandom_range(0, 9) < 3);
          default: begin
            pop <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  initial begin
    phase_kind_t kind;
    logic [3:0]  bg;
    logic [3:0]  fg;
    cycle_count  = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    push         = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_BACKGROUND;
    cfg_data     = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the reset colours.
    send_request(pack_request(OP_READ, 8'h00, 5'd0, 7'd0));
    send_request(pack_request(OP_PUT, 8'h41, 5'd0, 7'd0));
    send_request(pack_request(OP_PUT, 8'hFF, 5'd31, 7'd127));
    send_request(pack_request(OP_PUT, 8'h80, 5'd0, 7'd0));
    send_request(pack_request(OP_PUT, 8'h00, 5'd0, 7'd0));
    send_request(pack_request(OP_PUT, NEWLINE_CODE, 5'd0, 7'd0));
    send_request(pack_request(OP_PUT, 8'h7F, 5'd0, 7'd0));
    send_request(pack_request(OP_READ, 8'hFF, 5'd0, 7'd0));
    // A top-bit character must not spread into the colour bits.
    send_request(pack_request(OP_READ, 8'h00, 5'd0, 7'd1));
    send_request(pack_request(OP_READ, 8'h00, 5'd0, 7'd2));
    send_request(pack_request(OP_READ, 8'h00, 5'd1, 7'd0));
    send_request(pack_request(OP_READ, 8'h00, 5'd24, 7'd79));
    send_request(pack_request(OP_READ, 8'h00, 5'd25, 7'd0));
    send_request(pack_request(OP_READ, 8'h00, 5'd0, 7'd80));
    send_request(pack_request(OP_READ, 8'hFF, 5'd31, 7'd127));
    send_request(pack_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127));
    send_request(pack_request(OP_UNUSED, 8'h00, 5'd0, 7'd0));
    send_request(pack_request(OP_CLEAR, 8'hFF, 5'd31, 7'd127));
    send_request(pack_request(OP_READ, 8'h00, 5'd0, 7'd0));
    send_request(pack_request(OP_READ, 8'h00, 5'd1, 7'd0));
    send_request(pack_request(OP_PUT, 8'h5A, 5'd31, 7'd127));
    send_request(pack_request(OP_READ, 8'hFF, 5'd0, 7'd0));
    drain(4);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          bg = 4'hF;
          fg = 4'h0;
        end
        1: begin
          bg = 4'h0;
          fg = 4'hF;
        end
        2: begin
          bg = 4'hF;
          fg = 4'hF;
        end
        3: begin
          bg = 4'h0;
          fg = 4'h0;
        end
        default: begin
          bg = 4'($urandom);
          fg = 4'($urandom);
        end
      endcase
      set_colours(bg, fg);
      kind = phase_kind_t'(phase % 3 == 0 ? SCROLL_PHASE : (phase % 3 == 1 ? TEXT_PHASE
                                                                           : MIXED_PHASE));
      if (phase == 2) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(kind));
      end
      drain(4);
    end

    drain(20);
    if (failures == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### text_console_writer.f
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
verif/tcw_screen_checker.sv
verif/tb_text_console_writer.sv
